### rtl/core/srl_pkg.sv
// ----------------------------------------------------------------------------
// srl_pkg: shared types and constants for the sorted record list
// Record, request and response layouts, action and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package srl_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned TagW     = 16;
  localparam int unsigned ScoreW   = 16;
  localparam int unsigned CountW   = 5;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_PUSH   = 2'd1,
    ACT_POP    = 2'd2,
    ACT_IGNORE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [TagW-1:0]          tag;
    logic signed [ScoreW-1:0] score;
  } rec_t;

  typedef struct packed {
    logic [1:0]               action;
    logic [TagW-1:0]          record_tag;
    logic signed [ScoreW-1:0] record_score;
  } req_t;

  typedef struct packed {
    logic [TagW-1:0]          popped_tag;
    logic signed [ScoreW-1:0] popped_score;
    logic [1:0]               status;
    logic [CountW-1:0]        entry_count;
    logic                     is_empty;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/core/sorted_record_list.sv
// ----------------------------------------------------------------------------
// sorted_record_list: bounded table of tagged records in ascending score order
// Records live in a circular store addressed from a head pointer. Push and
// pop move the head; an ordered insert scans from the front, sliding each
// smaller record one slot towards the front, and drops the new record into
// the slot freed just ahead of the first record that is not smaller.
// ----------------------------------------------------------------------------
//
//  channel   | ports                         | handshake
//  ----------+-------------------------------+---------------------------------
//  request   | start, busy, req_i            | taken when start & !busy
//  response  | result_valid_o, rsp_o         | one-cycle strobe, no back-pressure
//
//  Push, any error and the ignored action are decided in the accept
//  cycle; a pop first passes through S_POP, and an insert stays in S_SCAN
//  until it reaches its slot, since the single read port of the store
//  visits one record per cycle. busy is high while a pop or insert runs.
//  Reset clears the registers but not the store, which needs no clearing.
//  The receiver cannot stall: each response is presented for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_record_list #(
  parameter int unsigned CAPACITY = srl_pkg::Capacity
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire srl_pkg::req_t req_i,
  output logic               result_valid_o,
  output srl_pkg::rsp_t      rsp_o
);
  import srl_pkg::*;

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(CAPACITY - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POP
  } state_e;

  function automatic logic [AddrW-1:0] ptr_next(input logic [AddrW-1:0] p);
    return (p == LastAddr) ? '0 : p + AddrW'(1);
  endfunction

  function automatic logic [AddrW-1:0] ptr_prev(input logic [AddrW-1:0] p);
    return (p == '0) ? LastAddr : p - AddrW'(1);
  endfunction

  state_e           state_q, state_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] scan_ptr_q, scan_ptr_d;
  logic [CntW-1:0]  scan_idx_q, scan_idx_d;
  rec_t             new_rec_q, new_rec_d;
  rsp_t             rsp_q, rsp_d;
  logic             valid_q, valid_d;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  rec_t             mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  rec_t             mem_rdata;

  logic             accept;
  logic             full;
  logic             move_on;
  logic [1:0]       status;

  srl_mem #(
    .Depth (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign accept = start && (state_q == S_IDLE);
  assign full   = (count_q == FullCnt);
  // keep sliding while the record under the scan is strictly smaller
  assign move_on = (scan_idx_q < count_q) && (mem_rdata.score < new_rec_q.score);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    scan_ptr_d = scan_ptr_q;
    scan_idx_d = scan_idx_q;
    new_rec_d  = new_rec_q;
    valid_d    = 1'b0;
    status     = ST_OK;
    rsp_d      = rsp_q;
    mem_we     = 1'b0;
    mem_waddr  = ptr_prev(head_q);
    mem_wdata  = '{tag: req_i.record_tag, score: req_i.record_score};
    mem_raddr  = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rsp_d.popped_tag   = '0;
          rsp_d.popped_score = '0;
          unique case (action_e'(req_i.action))
            ACT_INSERT: begin
              if (full) begin
                status  = ST_FULL;
                valid_d = 1'b1;
              end else begin
                scan_ptr_d = head_q;
                scan_idx_d = '0;
                new_rec_d  = '{tag: req_i.record_tag, score: req_i.record_score};
                state_d    = S_SCAN;
              end
            end
            ACT_PUSH: begin
              if (full) begin
                status = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                head_d  = ptr_prev(head_q);
                count_d = count_q + CntW'(1);
              end
              valid_d = 1'b1;
            end
            ACT_POP: begin
              if (count_q == '0) begin
                status  = ST_EMPTY;
                valid_d = 1'b1;
              end else begin
                state_d = S_POP;
              end
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_prev(scan_ptr_q);
        if (move_on) begin
          // slide this record one slot towards the front and advance
          mem_wdata  = mem_rdata;
          mem_raddr  = ptr_next(scan_ptr_q);
          scan_ptr_d = ptr_next(scan_ptr_q);
          scan_idx_d = scan_idx_q + CntW'(1);
        end else begin
          mem_wdata = new_rec_q;
          head_d    = ptr_prev(head_q);
          count_d   = count_q + CntW'(1);
          valid_d   = 1'b1;
          state_d   = S_IDLE;
        end
      end

      S_POP: begin
        rsp_d.popped_tag   = mem_rdata.tag;
        rsp_d.popped_score = mem_rdata.score;
        head_d             = ptr_next(head_q);
        count_d            = count_q - CntW'(1);
        valid_d            = 1'b1;
        state_d            = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (valid_d) begin
      rsp_d.status      = status;
      rsp_d.entry_count = CountW'(count_d);
      rsp_d.is_empty    = (count_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      count_q    <= '0;
      valid_q    <= 1'b0;
      scan_ptr_q <= '0;
      scan_idx_q <= '0;
      new_rec_q  <= '0;
      rsp_q      <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      valid_q    <= valid_d;
      scan_ptr_q <= scan_ptr_d;
      scan_idx_q <= scan_idx_d;
      new_rec_q  <= new_rec_d;
      rsp_q      <= rsp_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

endmodule

`default_nettype wire

### rtl/core/srl_mem.sv
// ----------------------------------------------------------------------------
// srl_mem: record store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module srl_mem #(
  parameter int unsigned Depth = srl_pkg::Capacity,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire srl_pkg::rec_t     wdata_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output srl_pkg::rec_t          rdata_o
);
  import srl_pkg::*;

  rec_t mem_q [Depth];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### tb/tb_sorted_record_list.sv
// ----------------------------------------------------------------------------
// tb_sorted_record_list: self-checking bench for the sorted record list
// Drives insert, push, pop and ignored requests through the start/busy
// handshake and predicts every response with a behavioural copy of the table.
// Each response is checked field by field, in order, against the predictions.
// ----------------------------------------------------------------------------

module tb_sorted_record_list;

  import srl_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  logic result_valid_o;
  rsp_t rsp_o;

  int unsigned sender_idle_pct = 0;
  int unsigned quiet_cycles    = 0;

  // Behavioural copy of the table and the queue of responses it predicts
  class sorted_table_model;
    rec_t        entries [Capacity];
    int unsigned held;
    rsp_t        pending_results [$];
    int unsigned mismatches;

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    function void note_request(req_t r);
      rsp_t        exp;
      int unsigned pos;
      int unsigned i;
      exp        = '0;
      exp.status = ST_OK;
      case (r.action)
        ACT_INSERT, ACT_PUSH: begin
          if (held >= Capacity) begin
            exp.status = ST_FULL;
          end else begin
            pos = 0;
            // a new record goes ahead of equal scores
            if (r.action == ACT_INSERT) begin
              while (pos < held && $signed(entries[pos].score) < $signed(r.record_score))
                pos++;
            end
            for (i = held; i > pos; i--) entries[i] = entries[i-1];
            entries[pos].tag   = r.record_tag;
            entries[pos].score = r.record_score;
            held++;
          end
        end
        ACT_POP: begin
          if (held == 0) begin
            exp.status = ST_EMPTY;
          end else begin
            exp.popped_tag   = entries[0].tag;
            exp.popped_score = entries[0].score;
            for (i = 1; i < held; i++) entries[i-1] = entries[i];
            held--;
          end
        end
        default: ;
      endcase
      exp.entry_count = CountW'(held);
      exp.is_empty    = (held == 0);
      pending_results.push_back(exp);
    endfunction

    task report_mismatch(string what, logic [31:0] got_v, logic [31:0] exp_v);
      $display("%0t: %s: got %0h, expected %0h", $time, what, got_v, exp_v);
      mismatches++;
    endtask

    task check_response(rsp_t got);
      rsp_t exp;
      if (pending_results.size() == 0) begin
        report_mismatch("response with no transaction outstanding", got.status, '0);
        return;
      end
      exp = pending_results.pop_front();
      if (got.popped_tag !== exp.popped_tag)
        report_mismatch("popped_tag", got.popped_tag, exp.popped_tag);
      if (got.popped_score !== exp.popped_score)
        report_mismatch("popped_score", got.popped_score, exp.popped_score);
      if (got.status !== exp.status)
        report_mismatch("status", got.status, exp.status);
      if (got.entry_count !== exp.entry_count)
        report_mismatch("entry_count", got.entry_count, exp.entry_count);
      if (got.is_empty !== exp.is_empty)
        report_mismatch("is_empty", got.is_empty, exp.is_empty);
    endtask
  endclass

  sorted_table_model model = new();

  sorted_record_list u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sample both channels at the edge, before any update of that edge lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) model.check_response(rsp_o);
      if (start && !busy) model.note_request(req_i);
      if (result_valid_o || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("** sorted_record_list: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic req_t make_req(action_e act, logic [TagW-1:0] tag,
                                    logic signed [ScoreW-1:0] score);
    req_t r;
    r.action       = act;
    r.record_tag   = tag;
    r.record_score = score;
    return r;
  endfunction

  // Mix full-range scores with a narrow band (ties) and the extremes
  function automatic logic signed [ScoreW-1:0] rand_score();
    logic signed [ScoreW-1:0] v;
    case ($urandom_range(3))
      0: begin
        v = ScoreW'($urandom_range(8));
        v = v - 16'sd4;
      end
      1: begin
        case ($urandom_range(3))
          0:       v = 16'sh8000;
          1:       v = 16'sh7FFF;
          2:       v = 16'sh0000;
          default: v = -16'sd1;
        endcase
      end
      default: v = ScoreW'($urandom);
    endcase
    return v;
  endfunction

  // Hold the transaction until taken; drop start only across idle cycles
  task automatic send_request(input req_t r);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic run_directed();
    int unsigned k;
    send_request(make_req(ACT_POP,    16'h1234, 16'sh0100));
    send_request(make_req(ACT_IGNORE, 16'hFFFF, 16'sh7FFF));
    send_request(make_req(ACT_INSERT, 16'hFFFF, 16'sh7FFF));
    send_request(make_req(ACT_INSERT, 16'h0000, 16'sh8000));
    send_request(make_req(ACT_INSERT, 16'h0001, 16'sh8000));
    send_request(make_req(ACT_PUSH,   16'h0002, 16'sh7FFF));
    send_request(make_req(ACT_INSERT, 16'h0003, 16'sh0000));
    // fill to capacity, then try both kinds of insert on a full table
    for (k = 5; k < Capacity; k++)
      send_request(make_req(ACT_PUSH, 16'(k * 16'h1111), rand_score()));
    send_request(make_req(ACT_INSERT, 16'hAAAA, 16'sh0000));
    send_request(make_req(ACT_PUSH,   16'h5555, 16'sh8000));
    send_request(make_req(ACT_POP,    16'h0000, 16'sh0000));
    send_request(make_req(ACT_POP,    16'hFFFF, 16'shFFFF));
  endtask

  // Alternate runs that mostly fill with runs that mostly drain
  task automatic run_random(input int unsigned n_items);
    int unsigned done_cnt;
    int unsigned run_left;
    int unsigned roll;
    bit          filling;
    req_t        r;
    done_cnt = 0;
    run_left = 0;
    filling  = 1'b0;
    while (done_cnt < n_items) begin
      if (run_left == 0) begin
        filling  = !filling;
        run_left = $urandom_range(8, 40);
      end
      run_left--;
      r.record_tag   = TagW'($urandom);
      r.record_score = rand_score();
      roll = $urandom_range(99);
      if (roll < 3)
        r.action = ACT_IGNORE;
      else if (roll < (filling ? 25 : 70))
        r.action = ACT_POP;
      else if ($urandom_range(3) == 0)
        r.action = ACT_PUSH;
      else
        r.action = ACT_INSERT;
      send_request(r);
      if (r.action != ACT_IGNORE) done_cnt++;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 22;
    run_directed();
    run_random(500);
    sender_idle_pct = 68;
    run_random(500);
    sender_idle_pct = 0;
    run_random(500);
    start <= 1'b0;

    while (model.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (model.mismatches == 0) begin
      $display("** sorted_record_list: PASSED **");
    end else begin
      $display("** sorted_record_list: FAILED **");
    end
    $finish;
  end

endmodule
